[sv/arpnh_pkg.sv]
// shared types and constants for the arp next-hop resolver
// depends on nothing; every other file of the block but arpnh_ram imports it
package arpnh_pkg;

    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int STAMP_W         = 64;
    localparam int OPCODE_W        = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_W           = 32;
    localparam int CACHE_DEPTH_DEF = 16;

    // register reset values, first octet in the low byte
    localparam logic [IP_W-1:0] LOCAL_RST   = 32'd251789322;  // 10.0.2.15
    localparam logic [IP_W-1:0] GATEWAY_RST = 32'd33685514;   // 10.0.2.2
    localparam logic [IP_W-1:0] MASK_RST    = 32'd16777215;   // 255.255.255.0

    typedef enum logic [OPCODE_W-1:0] {
        OP_LEARN   = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL   = 2'd0,
        CFG_GATEWAY = 2'd1,
        CFG_MASK    = 2'd2
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load_item;  // capture the incoming item
        logic prep;       // route, broadcast test, first cache read
        logic scan;       // compare one cache entry
        logic update;     // cache, stamp and gateway latch writes
        logic finish;     // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;  // the item has to walk the cache
        logic scan_done;  // current entry ends the walk
        logic out_free;   // output register can take a result
    } t_stat;

endpackage

[sv/arpnh_in_if.sv]
// input channel of the resolver: valid/ready plus one request item
// depends on arpnh_pkg
interface arpnh_in_if import arpnh_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [IP_W-1:0]     dst_ip;
    logic [MAC_W-1:0]    mac_in;

    modport source (output valid, output opcode, output dst_ip, output mac_in, input ready);
    modport sink   (input valid, input opcode, input dst_ip, input mac_in, output ready);

endinterface

[sv/arpnh_out_if.sv]
// output channel of the resolver: valid/ready plus one result item
// depends on arpnh_pkg
interface arpnh_out_if import arpnh_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             found;
    logic [MAC_W-1:0] mac_out;
    logic [IP_W-1:0]  hop_ip;
    logic             broadcast_hit;

    modport source (output valid, output found, output mac_out, output hop_ip,
                    output broadcast_hit, input ready);
    modport sink   (input valid, input found, input mac_out, input hop_ip,
                    input broadcast_hit, output ready);

endinterface

[sv/arpnh_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
module arpnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/arpnh_ctrl.sv]
// sequencing state machine of the resolver
// depends on arpnh_pkg; drives the datapath through t_cmd, reads t_stat
module arpnh_ctrl import arpnh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_UPDATE,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (r_in_ready && i_in_valid) n_state = ST_PREP;
            ST_PREP:   n_state = i_stat.need_scan ? ST_SCAN : ST_UPDATE;
            ST_SCAN:   if (i_stat.scan_done) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_FIN;
            ST_FIN:    if (i_stat.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == ST_IDLE);
        end
    end

    always_comb begin
        o_cmd.load_item = r_in_ready && i_in_valid;
        o_cmd.prep      = (r_state == ST_PREP);
        o_cmd.scan      = (r_state == ST_SCAN);
        o_cmd.update    = (r_state == ST_UPDATE);
        o_cmd.finish    = (r_state == ST_FIN) && i_stat.out_free;
    end

    assign o_in_ready = r_in_ready;

    a_ready_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready == (r_state == ST_IDLE))
        else $error("input ready out of step with idle state");

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.scan_done |-> (r_state == ST_SCAN))
        else $error("scan end reported outside a scan");

endmodule

[sv/arpnh_dp.sv]
// datapath of the resolver: config registers, cache rams, scan and result logic
// depends on arpnh_pkg and arpnh_ram; commanded by arpnh_ctrl
module arpnh_dp import arpnh_pkg::*; #(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [IP_W-1:0]      i_dst_ip,
    input  logic [MAC_W-1:0]     i_mac_in,
    input  logic                 i_out_ready,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    output logic                 o_found,
    output logic [MAC_W-1:0]     o_mac_out,
    output logic [IP_W-1:0]      o_hop_ip,
    output logic                 o_broadcast_hit
);

    localparam int IDX_W   = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int IPMAC_W = IP_W + MAC_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(CACHE_DEPTH - 1);

    function automatic logic is_bcast(input logic [IP_W-1:0] ip,
                                      input logic [IP_W-1:0] own_ip,
                                      input logic [IP_W-1:0] mask);
        return (ip == '1) || ((mask != '0) && (ip == (own_ip | ~mask)));
    endfunction

    function automatic logic [IP_W-1:0] pick_hop(input logic [IP_W-1:0] dst,
                                                 input logic [IP_W-1:0] own_ip,
                                                 input logic [IP_W-1:0] gw,
                                                 input logic [IP_W-1:0] mask);
        logic [IP_W-1:0] hop;
        if ((dst == gw) || is_bcast(dst, own_ip, mask)) begin
            hop = dst;
        end else if ((mask != '0) && ((dst & mask) == (own_ip & mask))) begin
            hop = dst;
        end else begin
            hop = (gw == '0) ? dst : gw;
        end
        return hop;
    endfunction

    // configuration
    logic [IP_W-1:0] r_local, r_gateway, r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local   <= LOCAL_RST;
            r_gateway <= GATEWAY_RST;
            r_mask    <= MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOCAL:   r_local   <= i_cfg_wdata[IP_W-1:0];
                CFG_GATEWAY: r_gateway <= i_cfg_wdata[IP_W-1:0];
                CFG_MASK:    r_mask    <= i_cfg_wdata[IP_W-1:0];
                default:     ;
            endcase
        end
    end

    // item and scan registers
    t_opcode             r_op;
    logic [IP_W-1:0]     r_ip;
    logic [MAC_W-1:0]    r_mac;
    logic [IP_W-1:0]     r_hop;
    logic [IP_W-1:0]     r_key;
    logic                r_bcast;
    logic                r_hit;
    logic [MAC_W-1:0]    r_hit_mac;
    logic [IDX_W-1:0]    r_rd_idx, r_cmp_idx, r_slot;
    logic [STAMP_W-1:0]  r_min;
    logic [CACHE_DEPTH-1:0] r_valid;
    logic [STAMP_W-1:0]  r_use_clock;
    logic [MAC_W-1:0]    r_gw_mac;
    logic                r_gw_known;

    // ram ports
    logic [IPMAC_W-1:0]  ipmac_rd;
    logic [STAMP_W-1:0]  stamp_rd;
    logic                ipmac_we, stamp_we;
    logic [STAMP_W-1:0]  n_use_clock;

    arpnh_ram #(.WIDTH(IPMAC_W), .DEPTH(CACHE_DEPTH), .AW(IDX_W)) u_ipmac_ram (
        .i_clk   (i_clk),
        .i_we    (ipmac_we),
        .i_waddr (r_slot),
        .i_wdata ({r_ip, r_mac}),
        .i_raddr (r_rd_idx),
        .o_rdata (ipmac_rd)
    );

    arpnh_ram #(.WIDTH(STAMP_W), .DEPTH(CACHE_DEPTH), .AW(IDX_W)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (r_slot),
        .i_wdata (n_use_clock),
        .i_raddr (r_rd_idx),
        .o_rdata (stamp_rd)
    );

    // routing, evaluated during prep
    logic [IP_W-1:0] hop;
    logic            bcast_any;

    assign hop       = pick_hop(r_ip, r_local, r_gateway, r_mask);
    assign bcast_any = is_bcast(r_ip, r_local, r_mask) || is_bcast(hop, r_local, r_mask);

    // entry compare
    logic [IP_W-1:0]  d_ip;
    logic [MAC_W-1:0] d_mac;
    logic             e_valid, e_match, learn_stop, e_stop, e_last;
    logic             learn_write, hit_write;

    assign d_ip        = ipmac_rd[IPMAC_W-1:MAC_W];
    assign d_mac       = ipmac_rd[MAC_W-1:0];
    assign e_valid     = r_valid[r_cmp_idx];
    assign e_match     = e_valid && (d_ip == r_key);
    assign learn_stop  = e_match || !e_valid;
    assign e_stop      = (r_op == OP_LEARN) ? learn_stop : e_match;
    assign e_last      = (r_cmp_idx == LAST);
    assign learn_write = (r_op == OP_LEARN) && (r_ip != '0);
    assign hit_write   = (r_op == OP_RESOLVE) && r_hit;
    assign ipmac_we    = i_cmd.update && learn_write;
    assign stamp_we    = i_cmd.update && (learn_write || hit_write);
    assign n_use_clock = r_use_clock + STAMP_W'(1);

    always_comb begin
        o_stat.need_scan = learn_write || ((r_op == OP_RESOLVE) && !bcast_any);
        o_stat.scan_done = i_cmd.scan && (e_stop || e_last);
        o_stat.out_free  = !o_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_idx <= '0;
        end else if (i_cmd.load_item) begin
            r_rd_idx  <= '0;
        end else if (i_cmd.prep || i_cmd.scan) begin
            // read address runs one entry ahead of the compare
            r_cmp_idx <= r_rd_idx;
            r_rd_idx  <= (r_rd_idx == LAST) ? r_rd_idx : r_rd_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= t_opcode'(i_opcode);
            r_ip  <= i_dst_ip;
            r_mac <= i_mac_in;
        end
        if (i_cmd.prep) begin
            r_hop   <= hop;
            r_bcast <= bcast_any;
            r_key   <= (r_op == OP_RESOLVE) ? hop : r_ip;
            r_hit   <= 1'b0;
        end
        if (i_cmd.scan) begin
            if (r_op == OP_LEARN) begin
                // first match or hole ends the walk, else track oldest stamp
                if (learn_stop || (r_cmp_idx == '0) || (stamp_rd < r_min)) begin
                    r_slot <= r_cmp_idx;
                    r_min  <= stamp_rd;
                end
            end else if (e_match) begin
                r_hit     <= 1'b1;
                r_slot    <= r_cmp_idx;
                r_hit_mac <= d_mac;
            end
        end
    end

    // cache state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_use_clock <= '0;
            r_gw_known  <= 1'b0;
        end else if (i_cmd.update) begin
            if (stamp_we) begin
                r_use_clock <= n_use_clock;
            end
            if (learn_write) begin
                r_valid[r_slot] <= 1'b1;
            end
            if ((r_op == OP_LEARN) && (r_ip == r_gateway)) begin
                r_gw_known <= 1'b1;
            end
            if (r_op == OP_CLEAR) begin
                r_valid    <= '0;
                r_gw_known <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && (r_op == OP_LEARN) && (r_ip == r_gateway)) begin
            r_gw_mac <= r_mac;
        end
    end

    // result
    logic             res_found, res_bcast;
    logic [MAC_W-1:0] res_mac;
    logic [IP_W-1:0]  res_hop;

    always_comb begin
        res_found = 1'b0;
        res_bcast = 1'b0;
        res_mac   = '0;
        res_hop   = '0;
        if (r_op == OP_RESOLVE) begin
            res_hop = r_hop;
            if (r_bcast) begin
                res_found = 1'b1;
                res_bcast = 1'b1;
                res_mac   = '1;
            end else if (r_hit) begin
                res_found = 1'b1;
                res_mac   = r_hit_mac;
            end else if (r_gw_known && (r_hop == r_gateway)) begin
                res_found = 1'b1;
                res_mac   = r_gw_mac;
            end
        end
    end

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_found         <= res_found;
            o_mac_out       <= res_mac;
            o_hop_ip        <= res_hop;
            o_broadcast_hit <= res_bcast;
        end
    end

    assign o_out_valid = r_out_valid;

    a_learn_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && learn_write) |=> r_valid[$past(r_slot)])
        else $error("learned entry not marked valid");

    a_use_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_use_clock == $past(r_use_clock)) ||
                            (r_use_clock == $past(r_use_clock) + STAMP_W'(1))))
        else $error("use clock moved by more than one");

    a_rd_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_idx <= LAST) && (r_cmp_idx <= LAST))
        else $error("cache index past last entry");

endmodule

[sv/arp_next_hop_resolver.sv]
// result registered after prep, scan over 1..CACHE_DEPTH entries, update and finish;
// learn of ip zero, broadcast, clear and no-op skip the walk
// the next item is taken in only once the last has finished; the walk reads one entry
// per cycle over the cache rams' single read port
// a finished result waits in the output register while the next item is taken in
// reset (synchronous, active low): cache empty, gateway mac unknown, use clock zero
module arp_next_hop_resolver import arpnh_pkg::*; #(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    arpnh_in_if.sink             i_in,
    arpnh_out_if.source          o_out
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // sequencer: idle, prep, scan, update, finish
    arpnh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: config registers, cache rams, lru scan, output register
    arpnh_dp #(.CACHE_DEPTH(CACHE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_in.opcode),
        .i_dst_ip        (i_in.dst_ip),
        .i_mac_in        (i_in.mac_in),
        .i_out_ready     (o_out.ready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out.valid),
        .o_found         (o_out.found),
        .o_mac_out       (o_out.mac_out),
        .o_hop_ip        (o_out.hop_ip),
        .o_broadcast_hit (o_out.broadcast_hit)
    );

    // input transfer happens only while the sequencer sits idle
    assign i_in.ready = in_ready;

endmodule
